>>> sv/qpht_pkg.sv
// Shared types, constants and helpers for the quadratic probe hash table.
package qpht_pkg;

  localparam int KEY_W      = 32;
  localparam int WORD_W     = KEY_W + 1;
  localparam int MOD_W      = 11;
  localparam int COEF_W     = 10;
  localparam int SLOT_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIGIT_BITS = 8;
  localparam int DIV_STEPS  = KEY_W / DIGIT_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef logic [1:0] outcome_t;

  localparam outcome_t OUT_INSERTED  = 2'd0;
  localparam outcome_t OUT_FOUND     = 2'd1;
  localparam outcome_t OUT_FULL      = 2'd2;
  localparam outcome_t OUT_NOT_FOUND = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE     = 2'd2;

  localparam logic [MOD_W-1:0]  TS_RESET = 11'd1024;
  localparam logic [COEF_W-1:0] LC_RESET = 10'd1;
  localparam logic [COEF_W-1:0] SC_RESET = 10'd1;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COEF_LIN,
    ST_COEF_SQ,
    ST_HASH,
    ST_PROBE
  } state_t;

  // a + b mod m, both operands already below m
  function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_W-1:0];
  endfunction

endpackage

>>> sv/qpht_mod_unit.sv
// Iterative remainder unit: 32-bit dividend mod 11-bit divisor, 8 bits per cycle.
module qpht_mod_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qpht_pkg::KEY_W-1:0]  dividend,
  input  logic [qpht_pkg::MOD_W-1:0]  divisor,
  output logic                        done,
  output logic [qpht_pkg::MOD_W-1:0]  remainder
);
  import qpht_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0]  quo_r, quo_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [MOD_W-1:0]  div_r, div_nxt;
  logic [MOD_W-1:0]  rem_step;
  logic [MOD_W:0]    trial;

  always_comb begin
    rem_step = rem_r;
    trial    = '0;
    for (int s = 0; s < DIGIT_BITS; s++) begin
      trial = {rem_step, quo_r[KEY_W-1-s]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_step = trial[MOD_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      quo_nxt = quo_r << DIGIT_BITS;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");

endmodule

>>> sv/qpht_mem.sv
// Slot memory: occupied bit and key per slot, one write and one registered read port.
module qpht_mem #(
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [qpht_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [qpht_pkg::WORD_W-1:0] rdata
);
  import qpht_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/quadratic_probe_hash_table.sv
// Top level of the quadratic probe hash table: control, probe datapath, configuration.
//
//  channel  ports                         handshake
//  -------  ----------------------------  ------------------------------------
//  input    start, busy, in_item          item taken when start & !busy
//  result   out_strobe, out_item          one-cycle strobe, always taken
//  config   cfg_valid, cfg_ready,         write when cfg_valid & cfg_ready
//           cfg_index, cfg_data           (cfg_ready is tied high)
//
// After an item is taken, the remainder unit forms its home slot, the first slot memory
// read is issued, then one slot is read per probe; an item makes from one probe up to as
// many probes as the table size. Busy falls while the result strobe is high unless a
// config write is pending, so no new item is taken before the last one's result.
// After reset a clearing pass writes every slot, with busy high.
// After reset and after each config write the coefficients are reduced mod the table
// size, with busy high. Results cannot be stalled.
module quadratic_probe_hash_table #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  qpht_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output qpht_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qpht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qpht_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qpht_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

  state_t             state_r, state_nxt;
  logic [MOD_W-1:0]   ts_r;
  logic [COEF_W-1:0]  lc_r, sc_r;
  logic               recalc_r;
  logic [MOD_W-1:0]   lcm_r, d0_r, dd_r;
  logic               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [MOD_W-1:0]   pos_r, delta_r, addr_d_r, ev_cnt_r;
  logic               rd_vld_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               out_strobe_r;
  out_item_t          out_item_r;

  logic [MOD_W-1:0]   m;
  logic [KEY_W-1:0]   key_bits, key_mag;
  logic [MOD_W-1:0]   home;
  logic               div_start, div_done;
  logic [KEY_W-1:0]   div_dividend;
  logic [MOD_W-1:0]   div_rem;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;
  logic               ev_occ, ev_match, ev_last, term;
  out_item_t          result;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE) || recalc_r;

  always_comb begin
    if (ts_r == '0) begin
      m = MOD_W'(1);
    end else if (32'(ts_r) > MAX_SLOTS) begin
      m = MOD_W'(MAX_SLOTS);
    end else begin
      m = ts_r;
    end
  end

  assign key_bits = in_item.key;
  assign key_mag  = key_bits[KEY_W-1] ? (-key_bits) : key_bits;

  // floor-mod of a negative key
  assign home = (key_r[KEY_W-1] && (div_rem != '0)) ? (m - div_rem) : div_rem;

  assign ev_occ   = mem_rdata[KEY_W];
  assign ev_match = (mem_rdata[KEY_W-1:0] == key_r);
  assign ev_last  = (ev_cnt_r == (m - MOD_W'(1)));
  assign term     = rd_vld_r && (!ev_occ || (cmd_r == CMD_SEARCH && ev_match) || ev_last);

  always_comb begin
    result.outcome = (cmd_r == CMD_INSERT) ? OUT_FULL : OUT_NOT_FOUND;
    result.slot    = '0;
    if (!ev_occ) begin
      if (cmd_r == CMD_INSERT) begin
        result.outcome = OUT_INSERTED;
        result.slot    = addr_d_r[SLOT_W-1:0];
      end
    end else if (cmd_r == CMD_SEARCH && ev_match) begin
      result.outcome = OUT_FOUND;
      result.slot    = addr_d_r[SLOT_W-1:0];
    end
  end

  qpht_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (m),
    .done      (div_done),
    .remainder (div_rem)
  );

  qpht_mem #(
    .DEPTH (MAX_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (recalc_r) begin
          state_nxt = ST_COEF_LIN;
        end else if (start) begin
          state_nxt = ST_HASH;
        end
      end
      ST_COEF_LIN: begin
        if (div_done) state_nxt = ST_COEF_SQ;
      end
      ST_COEF_SQ: begin
        if (div_done) state_nxt = ST_IDLE;
      end
      ST_HASH: begin
        if (div_done) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (term) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_start    = 1'b0;
    div_dividend = key_mag;
    mem_we       = 1'b0;
    mem_waddr    = AW'(addr_d_r);
    mem_wdata    = {1'b1, key_r};
    mem_re       = 1'b0;
    mem_raddr    = AW'(pos_r);
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        div_start = recalc_r || start;
        if (recalc_r) div_dividend = KEY_W'(lc_r);
      end
      ST_COEF_LIN: begin
        div_start    = div_done;
        div_dividend = KEY_W'(sc_r);
      end
      ST_PROBE: begin
        mem_re = !term;
        mem_we = rd_vld_r && !ev_occ && (cmd_r == CMD_INSERT);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      ts_r         <= TS_RESET;
      lc_r         <= LC_RESET;
      sc_r         <= SC_RESET;
      recalc_r     <= 1'b1;
      clr_cnt_r    <= '0;
      rd_vld_r     <= 1'b0;
      ev_cnt_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= mem_re;
      out_strobe_r <= (state_r == ST_PROBE) && term;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_HASH) begin
        ev_cnt_r <= '0;
      end else if (state_r == ST_PROBE && rd_vld_r) begin
        ev_cnt_r <= ev_cnt_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        recalc_r <= 1'b1;
        case (cfg_index)
          REG_TABLE_SIZE: ts_r <= cfg_data;
          REG_LINEAR:     lc_r <= cfg_data[COEF_W-1:0];
          REG_SQUARE:     sc_r <= cfg_data[COEF_W-1:0];
          default: begin
          end
        endcase
      end else if (state_r == ST_IDLE && recalc_r) begin
        recalc_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && !recalc_r && start) begin
      cmd_r <= in_item.cmd;
      key_r <= key_bits;
    end
    if (state_r == ST_COEF_LIN && div_done) lcm_r <= div_rem;
    if (state_r == ST_COEF_SQ && div_done) begin
      d0_r <= add_mod(lcm_r, div_rem, m);
      dd_r <= add_mod(div_rem, div_rem, m);
    end
    if (state_r == ST_HASH && div_done) begin
      pos_r   <= home;
      delta_r <= d0_r;
    end else if (mem_re) begin
      pos_r    <= add_mod(pos_r, delta_r, m);
      delta_r  <= add_mod(delta_r, dd_r, m);
      addr_d_r <= pos_r;
    end
    if (state_r == ST_PROBE && term) out_item_r <= result;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("two results in consecutive cycles");

  a_insert_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE && mem_we) |=> (out_strobe_r && out_item_r.outcome == OUT_INSERTED))
    else $error("slot written without an inserted result");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_item_r.outcome == OUT_FULL || out_item_r.outcome == OUT_NOT_FOUND))
      |-> (out_item_r.slot == '0))
    else $error("slot not zero on a miss");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE && rd_vld_r) |-> (ev_cnt_r < m))
    else $error("probe count beyond table size");

endmodule
